FILE: src/spq_pkg.sv
`default_nettype none

package spq_pkg;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned KEY_W = 8;
  localparam int unsigned PAY_W = 16;
  localparam int unsigned STS_W = 2;
  localparam int unsigned CNT_W = 5;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK  = 2'd2;

  // Status codes.
  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic pop_front;
    logic pop_back;
  } ctrl_t;

endpackage

`default_nettype wire

FILE: src/spq_if.sv
`default_nettype none

interface spq_in_if import spq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] key;
  logic [PAY_W-1:0] payload;

  modport source (output valid, cmd, key, payload, input ready);
  modport sink   (input valid, cmd, key, payload, output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [STS_W-1:0] status;
  logic [KEY_W-1:0] out_key;
  logic [PAY_W-1:0] out_payload;
  logic [CNT_W-1:0] count;

  modport source (output valid, status, out_key, out_payload, count, input ready);
  modport sink   (input valid, status, out_key, out_payload, count, output ready);
endinterface

`default_nettype wire

FILE: src/spq_cell.sv
`default_nettype none

module spq_cell import spq_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ctrl_t            ctrl_i,
  input  wire logic [KEY_W-1:0] new_key_i,
  input  wire logic [PAY_W-1:0] new_payload_i,
  input  wire logic             left_valid_i,
  input  wire logic             left_ge_i,
  input  wire logic [KEY_W-1:0] left_key_i,
  input  wire logic [PAY_W-1:0] left_payload_i,
  input  wire logic             right_valid_i,
  input  wire logic [KEY_W-1:0] right_key_i,
  input  wire logic [PAY_W-1:0] right_payload_i,
  output logic                  valid_o,
  output logic                  ge_o,
  output logic [KEY_W-1:0]      key_o,
  output logic [PAY_W-1:0]      payload_o
);

  logic             valid_q, valid_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [PAY_W-1:0] payload_q, payload_d;

  // The cell keeps its entry on insert when it holds a key at least as large as the new one.
  assign ge_o = valid_q && (key_q >= new_key_i);

  always_comb begin
    valid_d   = valid_q;
    key_d     = key_q;
    payload_d = payload_q;
    if (ctrl_i.insert) begin
      valid_d = valid_q || left_valid_i;
      if (!ge_o) begin
        if (left_ge_i) begin
          key_d     = new_key_i;
          payload_d = new_payload_i;
        end else begin
          key_d     = left_key_i;
          payload_d = left_payload_i;
        end
      end
    end else if (ctrl_i.pop_front) begin
      valid_d   = right_valid_i;
      key_d     = right_key_i;
      payload_d = right_payload_i;
    end else if (ctrl_i.pop_back) begin
      valid_d = valid_q && right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

  assign valid_o   = valid_q;
  assign key_o     = key_q;
  assign payload_o = payload_q;

endmodule

`default_nettype wire

FILE: src/sorted_priority_queue.sv
`default_nettype none

// Channel   Interface    Role    Contents
// req_i     spq_in_if    sink    cmd, key, payload
// rsp_o     spq_out_if   source  status, out_key, out_payload, count
//
// The whole row of cells updates at the edge that accepts a command, and the result
// is loaded into the output register at that same edge.
// A new command is taken every cycle while the output register is empty or being drained.
// Reset clears the valid bit of every cell, the entry count and the output register's valid flag.
// A stalled result holds req_i off until it has been transferred.

module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spq_in_if.sink    req_i,
  spq_out_if.source rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Cell outputs along the chain. Slot 0 holds the highest key.
  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] cell_ge;
  logic [KEY_W-1:0] cell_key [DEPTH];
  logic [PAY_W-1:0] cell_pay [DEPTH];

  logic             full, empty, in_ready, in_fire;
  ctrl_t            ctrl;
  logic [CW-1:0]    count_q, count_d;
  logic [STS_W-1:0] status_d;
  logic [KEY_W-1:0] rkey_d, tail_key;
  logic [PAY_W-1:0] rpay_d, tail_pay;

  logic             out_valid_q;
  logic [STS_W-1:0] status_q;
  logic [KEY_W-1:0] rkey_q;
  logic [PAY_W-1:0] rpay_q;
  logic [CNT_W-1:0] rcnt_q;

  // Occupancy comes straight from the chain: the entries fill the low slots contiguously.
  assign full  = cell_valid[DEPTH-1];
  assign empty = !cell_valid[0];

  // The output register is the only buffer, so a transfer may enter whenever it drains.
  assign in_ready    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = in_ready;
  assign in_fire     = req_i.valid && in_ready;

  // Only legal operations reach the cells, so a dropped insert or an empty pop changes nothing.
  assign ctrl.insert    = in_fire && (req_i.cmd == CMD_INSERT) && !full;
  assign ctrl.pop_front = in_fire && (req_i.cmd == CMD_POP_FRONT) && !empty;
  assign ctrl.pop_back  = in_fire && (req_i.cmd == CMD_POP_BACK) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             l_valid, l_ge, r_valid;
    logic [KEY_W-1:0] l_key, r_key;
    logic [PAY_W-1:0] l_pay, r_pay;

    if (i == 0) begin : g_head
      // The head always takes the new entry unless it keeps its own.
      assign l_valid = 1'b1;
      assign l_ge    = 1'b1;
      assign l_key   = '0;
      assign l_pay   = '0;
    end else begin : g_body
      assign l_valid = cell_valid[i-1];
      assign l_ge    = cell_ge[i-1];
      assign l_key   = cell_key[i-1];
      assign l_pay   = cell_pay[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_key   = '0;
      assign r_pay   = '0;
    end else begin : g_inner
      assign r_valid = cell_valid[i+1];
      assign r_key   = cell_key[i+1];
      assign r_pay   = cell_pay[i+1];
    end

    spq_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .new_key_i      (req_i.key),
      .new_payload_i  (req_i.payload),
      .left_valid_i   (l_valid),
      .left_ge_i      (l_ge),
      .left_key_i     (l_key),
      .left_payload_i (l_pay),
      .right_valid_i  (r_valid),
      .right_key_i    (r_key),
      .right_payload_i(r_pay),
      .valid_o        (cell_valid[i]),
      .ge_o           (cell_ge[i]),
      .key_o          (cell_key[i]),
      .payload_o      (cell_pay[i])
    );
  end

  // The back entry is the one valid cell whose right neighbour is empty; an OR tree gathers it.
  always_comb begin
    tail_key = '0;
    tail_pay = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_valid[i] && ((i == DEPTH - 1) || !cell_valid[(i + 1) % DEPTH])) begin
        tail_key = tail_key | cell_key[i];
        tail_pay = tail_pay | cell_pay[i];
      end
    end
  end

  always_comb begin
    status_d = STS_OK;
    rkey_d   = '0;
    rpay_d   = '0;
    count_d  = count_q;
    case (req_i.cmd)
      CMD_INSERT: begin
        if (full) begin
          status_d = STS_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status_d = STS_EMPTY;
        end else begin
          rkey_d  = cell_key[0];
          rpay_d  = cell_pay[0];
          count_d = count_q - CW'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status_d = STS_EMPTY;
        end else begin
          rkey_d  = tail_key;
          rpay_d  = tail_pay;
          count_d = count_q - CW'(1);
        end
      end
      default: begin
        // Unused command: no change, plain ok result.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
      rkey_q   <= rkey_d;
      rpay_q   <= rpay_d;
      rcnt_q   <= CNT_W'(count_d);
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.out_key     = rkey_q;
  assign rsp_o.out_payload = rpay_q;
  assign rsp_o.count       = rcnt_q;

  // Checks on the chain.
  logic [DEPTH-1:0] order_ok;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      order_ok[i] = (i == DEPTH - 1) || !cell_valid[(i + 1) % DEPTH] ||
                    (cell_key[i] >= cell_key[(i + 1) % DEPTH]);
    end
  end

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(count_q))
    else $error("entry count disagrees with the valid cells");

  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid & (cell_valid + DEPTH'(1))) == '0)
    else $error("valid cells are not a contiguous run from the head");

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    &order_ok)
    else $error("chain is not in descending key order");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl.insert, ctrl.pop_front, ctrl.pop_back}))
    else $error("more than one operation driven into the chain");

endmodule

`default_nettype wire
